[rtl/wbps_pkg.sv]
// Shared constants and types for the wildcard byte pattern scanner.
`default_nettype none
package wbps_pkg;

  // Pattern storage is fixed by the register map: two 64-bit words, one care bit per byte.
  localparam int PatBytes      = 16;
  localparam int PatLenW       = 5;
  localparam int MaxPatternDef = 16;
  localparam int OffsetW       = 32;

  // APB map: 64-bit registers at 8-byte strides.
  localparam int ApbDataW = 64;
  localparam int ApbAddrW = 5;
  localparam int RegIdxW  = 2;

  localparam logic [RegIdxW-1:0] RegPatLen  = 2'd0;
  localparam logic [RegIdxW-1:0] RegPatLow  = 2'd1;
  localparam logic [RegIdxW-1:0] RegPatHigh = 2'd2;
  localparam logic [RegIdxW-1:0] RegCare    = 2'd3;

  // Output word: found in bit 0, offset above it, padded to whole bytes.
  localparam int OutDataW = 40;

  typedef logic [PatBytes*8-1:0] pattern_t;
  typedef logic [PatBytes-1:0]   care_t;

endpackage
`default_nettype wire

[rtl/wildcard_byte_pattern_scanner_top.sv]
// Top level of the wildcard byte pattern scanner: input stage, scan state, result stage, APB regs.
`default_nettype none
// The scanner takes one byte per word on the slave stream (tlast ends a region) and returns
// exactly one result word per region: the offset of the first position where the pattern
// matches, or not-found on the region's last byte. Pattern bytes with a clear care bit match
// anything; an empty pattern or a region shorter than the pattern gives not-found. Throughput
// is one byte per cycle unless the master side stalls; a byte is held in the input register
// while the window shift and the 16 masked compares run; any result it gives is registered
// into the output register as the byte leaves the input register. The output register lets
// the next byte enter while a result waits; s_axis_tready drops only when both stages
// hold words and the master side stalls. The offset counter saturates at 0xFFFFFFFF.
// Registers (APB, 64-bit, byte address 8*i): 0 pattern_length, 1 pattern_low,
// 2 pattern_high, 3 care_mask. Write them only while no region is in flight.
module wildcard_byte_pattern_scanner_top #(
  parameter int MaxPattern = wbps_pkg::MaxPatternDef
) (
  input  var logic                          clk_i,
  input  var logic                          rst_ni,
  // APB configuration port
  input  var logic                          psel,
  input  var logic                          penable,
  input  var logic                          pwrite,
  input  var logic [wbps_pkg::ApbAddrW-1:0] paddr,
  input  var logic [wbps_pkg::ApbDataW-1:0] pwdata,
  output var logic [wbps_pkg::ApbDataW-1:0] prdata,
  output var logic                          pready,
  // byte stream in
  input  var logic                          s_axis_tvalid,
  output var logic                          s_axis_tready,
  input  var logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  var logic                          s_axis_tlast,  // last_byte
  // results out
  output var logic                          m_axis_tvalid,
  input  var logic                          m_axis_tready,
  output var logic [wbps_pkg::OutDataW-1:0] m_axis_tdata   // [0] found, [32:1] match_offset
);
  import wbps_pkg::*;

  localparam int LenW = ($clog2(MaxPattern + 1) > PatLenW) ? $clog2(MaxPattern + 1) : PatLenW;
  localparam logic [LenW-1:0] MaxLenC = LenW'(MaxPattern);

  // ---------------- configuration registers ----------------
  logic [PatLenW-1:0] pat_len_q;
  logic [63:0]        pat_low_q, pat_high_q;
  care_t              care_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               cfg_wr;

  assign reg_idx = paddr[ApbAddrW-1:ApbAddrW-RegIdxW];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  <= '0;
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegPatLen:  pat_len_q  <= pwdata[PatLenW-1:0];
        RegPatLow:  pat_low_q  <= pwdata;
        RegPatHigh: pat_high_q <= pwdata;
        RegCare:    care_q     <= pwdata[PatBytes-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPatLen:  prdata = ApbDataW'(pat_len_q);
      RegPatLow:  prdata = pat_low_q;
      RegPatHigh: prdata = pat_high_q;
      RegCare:    prdata = ApbDataW'(care_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       adv;        // stage holds a word and the result slot can take it
  logic       out_valid_q;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  // ---------------- scan state ----------------
  logic [MaxPattern-1:0][7:0] win_q, win_d;
  logic [OffsetW-1:0]         cnt_q, cnt_inc;
  logic                       answered_q;
  logic [LenW-1:0]            len_ext, len;
  logic                       match, hit, emit;

  // Lengths past the window depth are clamped to it.
  assign len_ext = LenW'(pat_len_q);
  assign len     = (len_ext > MaxLenC) ? MaxLenC : len_ext;

  // Window after this byte shifts in; entry k arrived k words ago.
  always_comb begin
    win_d[0] = byte_q;
    for (int k = 1; k < MaxPattern; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + OffsetW'(1);

  wbps_match #(
    .MaxPattern (MaxPattern),
    .LenW       (LenW)
  ) u_match (
    .win_i     (win_d),
    .len_i     (len),
    .pattern_i ({pat_high_q, pat_low_q}),
    .care_i    (care_q),
    .match_o   (match)
  );

  // A start is only tested once enough bytes of this region are in the window.
  assign hit  = (len != '0) && (cnt_inc >= OffsetW'(len)) && match;
  assign emit = !answered_q && (hit || last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      cnt_q      <= '0;
      answered_q <= 1'b0;
    end else if (adv) begin
      win_q <= win_d;
      if (last_q) begin
        cnt_q      <= '0;
        answered_q <= 1'b0;
      end else begin
        cnt_q      <= cnt_inc;
        answered_q <= answered_q || emit;
      end
    end
  end

  // ---------------- result register ----------------
  logic               found_q;
  logic [OffsetW-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      found_q  <= hit;
      offset_q <= hit ? (cnt_inc - OffsetW'(len)) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW-OffsetW-1)'(0), offset_q, found_q};

endmodule
`default_nettype wire

[rtl/wbps_match.sv]
// Masked compare of the byte window against the configured pattern.
`default_nettype none
module wbps_match #(
  parameter int MaxPattern = wbps_pkg::MaxPatternDef,
  parameter int LenW       = 5
) (
  input  var logic [MaxPattern-1:0][7:0] win_i,
  input  var logic [LenW-1:0]            len_i,
  input  var wbps_pkg::pattern_t         pattern_i,
  input  var wbps_pkg::care_t            care_i,
  output var logic                       match_o
);
  import wbps_pkg::*;

  localparam int WIdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  logic [PatBytes-1:0] ok;

  // Pattern byte i lines up with the byte received len-1-i words ago.
  for (genvar i = 0; i < PatBytes; i++) begin : g_cmp
    localparam logic [LenW-1:0] IdxC = LenW'(i);
    logic [LenW-1:0] idx;
    logic            active;
    assign idx    = len_i - IdxC - LenW'(1);
    assign active = (IdxC < len_i) && care_i[i];
    assign ok[i]  = !active || (win_i[idx[WIdxW-1:0]] == pattern_i[8*i +: 8]);
  end

  assign match_o = &ok;

endmodule
`default_nettype wire

[rtl/wbps_checker.sv]
// Port-level checks for the scanner, bound to its top level.
`default_nettype none
module wbps_checker (
  input var logic                          clk_i,
  input var logic                          rst_ni,
  input var logic                          pready,
  input var logic                          m_axis_tvalid,
  input var logic                          m_axis_tready,
  input var logic [wbps_pkg::OutDataW-1:0] m_axis_tdata
);
  import wbps_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Not-found carries a zero offset.
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OffsetW:1] == '0)
    else $error("not-found word with nonzero offset");

  // Padding bits above the offset stay clear.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:OffsetW+1] == '0)
    else $error("result padding not zero");

  // APB never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
